FILE: design/rc4_pkg.sv
// Shared types and constants of the RC4 keystream generator.
package rc4_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = 9;
  localparam int unsigned OpW        = 2;

  localparam logic [CountW-1:0] KeyLen = CountW'(256);

  typedef enum logic [OpW-1:0] {
    OP_REKEY = 2'd0,
    OP_KEY   = 2'd1,
    OP_GEN   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_WR2,
    S_RD3,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [ByteW-1:0] keystream_byte;
    logic             status;
  } result_t;

endpackage

FILE: design/rc4_in_if.sv
// Input channel: valid/ready handshake carrying one operation word.
interface rc4_in_if import rc4_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [OpW-1:0] opcode;
  logic [7:0]     key_byte;

  modport source (output valid, opcode, key_byte, input ready);
  modport sink   (input valid, opcode, key_byte, output ready);
endinterface

FILE: design/rc4_out_if.sv
// Output channel: valid/ready handshake carrying one keystream word.
interface rc4_out_if import rc4_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] keystream_byte;
  logic       status;

  modport source (output valid, keystream_byte, status, input ready);
  modport sink   (input valid, keystream_byte, status, output ready);
endinterface

FILE: design/rc4_keystream_generator_top.sv
// RC4 keystream generator: permutation table in RAM, sequencer and output register.
// A rekey word is done in S_IDLE; a key-byte word passes S_RD1, S_RD2 and S_WR2, and a
// generate word S_RD1 to S_OUT until its result sits in the output register; the next
// word is taken in the cycle after that. The order comes from the single read port of the
// table RAM, shared in turn by swap and final lookup; error or ignored words skip the RAM.
// Reset (asynchronous, active low) clears the indices, the key count and all entry valid
// bits, so the table reads as the identity permutation at once; no clearing pass is needed.
module rc4_keystream_generator_top import rc4_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rc4_in_if.sink    in_i,
  rc4_out_if.source out_o
);

  localparam int unsigned AddrW = $clog2(TableDepth);

  // Sequencer state and working registers.
  state_e state_q, state_d;
  op_e    op_q;
  logic [ByteW-1:0]  kb_q;
  logic [AddrW-1:0]  i_q, j_q;
  logic [CountW-1:0] count_q;
  logic [ByteW-1:0]  si_q, sj_q;
  logic              fwd_q;
  logic [AddrW-1:0]  rd_addr_q;

  // Per-entry valid bits: an entry that was never written since reset or rekey
  // reads as its own index, which is the identity permutation.
  logic [TableDepth-1:0] vld_q;

  result_t res_q;
  result_t out_q;
  logic    out_valid_q;

  // RAM interface.
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [ByteW-1:0] wdata;
  logic [AddrW-1:0] rd_addr;
  logic [ByteW-1:0] ram_rdata;
  logic [ByteW-1:0] rd_val;

  logic             accept;
  logic             key_done;
  logic [AddrW-1:0] j_new;
  logic [AddrW-1:0] t_addr;
  logic             out_load;
  op_e              in_op;

  assign in_op    = op_e'(in_i.opcode);
  assign accept   = in_i.valid && in_i.ready;
  assign key_done = (count_q == KeyLen);

  // Data read in the previous cycle, with the identity value for untouched entries.
  assign rd_val = vld_q[rd_addr_q] ? ram_rdata : rd_addr_q;

  // New j: the key schedule adds the key byte, the output step does not.
  assign j_new  = j_q + rd_val + ((op_q == OP_KEY) ? kb_q : '0);
  // After the swap S[i] holds the old S[j] and vice versa; the sum is the same.
  assign t_addr = si_q + sj_q;

  // The output register takes a new result when it is empty or being drained.
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  rc4_ram #(
    .Width (ByteW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_KEY:  if (!key_done) state_d = S_RD1;
            OP_GEN:  state_d = key_done ? S_RD1 : S_OUT;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RD1: state_d = S_RD2;
      S_RD2: state_d = S_WR2;
      S_WR2: state_d = (op_q == OP_GEN) ? S_RD3 : S_IDLE;
      S_RD3: state_d = S_OUT;
      S_OUT: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Output logic: handshake and RAM port control.
  always_comb begin
    in_i.ready = 1'b0;
    we         = 1'b0;
    waddr      = i_q;
    wdata      = rd_val;
    rd_addr    = rd_addr_q;
    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        rd_addr    = (in_op == OP_GEN) ? i_q + AddrW'(1) : i_q;
      end
      S_RD1: rd_addr = j_new;
      S_RD2: begin
        // First half of the swap: S[i] takes the old S[j].
        we    = 1'b1;
        waddr = i_q;
        wdata = rd_val;
      end
      S_WR2: begin
        // Second half of the swap: S[j] takes the old S[i].
        we      = 1'b1;
        waddr   = j_q;
        wdata   = si_q;
        rd_addr = t_addr;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      count_q     <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && in_op == OP_REKEY) begin
        vld_q   <= '0;
        i_q     <= '0;
        j_q     <= '0;
        count_q <= '0;
      end
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (state_q == S_RD1) begin
        j_q <= j_new;
        if (op_q == OP_GEN) begin
          i_q <= i_q + AddrW'(1);
        end
      end
      if (state_q == S_WR2 && op_q == OP_KEY) begin
        count_q <= count_q + CountW'(1);
        if (count_q + CountW'(1) == KeyLen) begin
          // Keying is finished: both indices restart from zero.
          i_q <= '0;
          j_q <= '0;
        end else begin
          i_q <= i_q + AddrW'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr;
    if (accept) begin
      op_q <= in_op;
      kb_q <= in_i.key_byte;
      // A generate word before keying finishes yields an error result.
      res_q.keystream_byte <= '0;
      res_q.status         <= 1'b1;
    end
    if (state_q == S_RD1) begin
      si_q <= rd_val;
    end
    if (state_q == S_RD2) begin
      sj_q <= rd_val;
    end
    if (state_q == S_WR2) begin
      // S[t] is read in the same cycle that S[j] is written; forward that value.
      fwd_q <= (t_addr == j_q);
    end
    if (state_q == S_RD3) begin
      res_q.keystream_byte <= fwd_q ? si_q : rd_val;
      res_q.status         <= 1'b0;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.keystream_byte = out_q.keystream_byte;
  assign out_o.status         = out_q.status;

  // The key count never passes the key length.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= KeyLen)
    else $error("key count exceeds key length");

  // The table is written only during the two swap cycles.
  a_write_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_RD2 || state_q == S_WR2))
    else $error("table written outside a swap");

  // A rekey word leaves the indices and the count at zero.
  a_rekey_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_op == OP_REKEY) |=> (i_q == '0 && j_q == '0 && count_q == '0))
    else $error("rekey did not clear the state");

  // The last key byte returns both indices to zero.
  a_key_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR2 && op_q == OP_KEY && count_q == KeyLen - CountW'(1))
    |=> (i_q == '0 && j_q == '0 && key_done))
    else $error("indices not cleared at end of keying");

  // Generating with a finished key schedule always gives an ok status.
  a_gen_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD3) |=> (res_q.status == 1'b0))
    else $error("generated word carries an error status");

endmodule

FILE: design/rc4_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rc4_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
